@@ rtl/bpagc_pkg.sv @@
// shared constants and types for the block peak agc
`default_nettype none

package bpagc_pkg;

  // fixed-point and register widths
  localparam int FRAC_BITS     = 16;
  localparam int REF_BITS      = 16;
  localparam int RATE_BITS     = 32;
  localparam int RATE_HALF     = 16;
  localparam int RATE_SHIFT    = 31;
  localparam int CFG_GAIN_BITS = 24;

  // apb port
  localparam int APB_ADDR_BITS = 5;
  localparam int APB_DATA_BITS = 32;

  // sample queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = 2;
  localparam int QCNT_BITS   = 3;

  // register reset values
  localparam logic [REF_BITS-1:0]      RST_REFERENCE    = 16'd16384;
  localparam logic [RATE_BITS-1:0]     RST_LOOP_RATE    = 32'd4096;
  localparam logic [CFG_GAIN_BITS-1:0] RST_GAIN_CEILING = 24'd0;
  localparam logic [CFG_GAIN_BITS-1:0] RST_INIT_GAIN    = 24'd65536;
  localparam int                       GAIN_UNITY       = 65536;

  // register indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_MODE_REAL    = 3'd0,
    REG_REFERENCE    = 3'd1,
    REG_LOOP_RATE    = 3'd2,
    REG_GAIN_CEILING = 3'd3,
    REG_INITIAL_GAIN = 3'd4
  } reg_idx_t;

  // gain update sequencer
  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SQRT   = 8'b0000_0010,
    ST_ERR    = 8'b0000_0100,
    ST_MUL_A  = 8'b0000_1000,
    ST_MUL_LO = 8'b0001_0000,
    ST_MUL_HI = 8'b0010_0000,
    ST_SUM    = 8'b0100_0000,
    ST_APPLY  = 8'b1000_0000
  } upd_state_t;

endpackage

`default_nettype wire

@@ rtl/bpagc_queue.sv @@
// front end: accepts sample beats and queues them for the scaler
`default_nettype none

module bpagc_queue
  import bpagc_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [SAMPLE_BITS-1:0]   in_i,
  input  logic [SAMPLE_BITS-1:0]   in_q,
  input  logic                     in_last,
  output logic                     head_valid,
  output logic [2*SAMPLE_BITS:0]   head,     // {last, q, i}
  input  logic                     pop
);

  localparam int EW = 2*SAMPLE_BITS + 1;

  logic [EW-1:0]        mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wptr;
  logic [QPTR_BITS-1:0] rptr;
  logic [QCNT_BITS-1:0] count;
  logic                 push;

  assign in_ready   = (count != QCNT_BITS'(QUEUE_DEPTH));
  assign push       = in_valid & in_ready;
  assign head_valid = (count != '0);
  assign head       = mem[rptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= {in_last, in_q, in_i};
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/bpagc_scaler.sv @@
// back end: gain multiply, round and saturate, peak and count tracking
`default_nettype none

module bpagc_scaler
  import bpagc_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int GAIN_BITS   = 24,
  parameter int MAX_BLOCK   = 4096,
  parameter int CNT_BITS    = 13
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       mode_real,
  input  logic [GAIN_BITS-1:0]       gain,
  input  logic                       head_valid,
  input  logic [2*SAMPLE_BITS:0]     head,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [SAMPLE_BITS-1:0]     out_i,
  output logic [SAMPLE_BITS-1:0]     out_q,
  output logic                       hold,
  output logic                       upd_start,
  input  logic                       upd_done,
  output logic [2*SAMPLE_BITS-1:0]   peak,
  output logic [CNT_BITS-1:0]        count
);

  localparam int SB  = SAMPLE_BITS;
  localparam int PW1 = SB + GAIN_BITS;
  localparam int RW  = PW1 + 1 - FRAC_BITS;
  localparam int PKW = 2*SB;

  localparam logic [RW-1:0]  LIM_POS = RW'((1 << (SB-1)) - 1);
  localparam logic [RW-1:0]  LIM_NEG = RW'(1 << (SB-1));
  localparam logic [SB-1:0]  SMAX    = SB'((1 << (SB-1)) - 1);
  localparam logic [SB-1:0]  SMIN    = SB'(1 << (SB-1));
  localparam logic [PW1:0]   HALF    = (PW1+1)'(1 << (FRAC_BITS-1));

  // round half away from zero on the magnitude, then saturate
  function automatic logic [SB-1:0] round_sat(input logic [PW1-1:0] p, input logic neg);
    logic [PW1:0]  sum;
    logic [RW-1:0] r;
    logic [SB-1:0] res;
    sum = {1'b0, p} + HALF;
    r   = sum[PW1:FRAC_BITS];
    if (neg) begin
      res = (r > LIM_NEG) ? SMIN : SB'(~r + 1'b1);
    end else begin
      res = (r > LIM_POS) ? SMAX : r[SB-1:0];
    end
    return res;
  endfunction

  logic [SB-1:0]  hd_i;
  logic [SB-1:0]  hd_q;
  logic           hd_last;
  logic [SB-1:0]  mag_i;
  logic [SB-1:0]  mag_q;
  logic           adv;

  // multiply stage
  logic           v1;
  logic [PW1-1:0] p_i1;
  logic [PW1-1:0] p_q1;
  logic           neg_i1;
  logic           neg_q1;
  logic           real1;
  logic           last1;

  // output stage results
  logic [SB-1:0]  oi_next;
  logic [SB-1:0]  oq_next;
  logic           load_out;

  // peak path
  logic                  v3;
  logic                  last3;
  logic signed [SB-1:0]  oi3;
  logic signed [SB-1:0]  oq3;
  logic                  v4;
  logic                  last4;
  logic [PKW-1:0]        sq_i4;
  logic [PKW-1:0]        sq_q4;
  logic [PKW-1:0]        msq;

  assign hd_i    = head[SB-1:0];
  assign hd_q    = head[2*SB-1:SB];
  assign hd_last = head[2*SB];
  assign mag_i   = hd_i[SB-1] ? (~hd_i + 1'b1) : hd_i;
  assign mag_q   = hd_q[SB-1] ? (~hd_q + 1'b1) : hd_q;

  assign adv      = ~out_valid | out_ready;
  assign pop      = head_valid & ~hold & (~v1 | adv);
  assign load_out = v1 & adv;
  assign oi_next  = round_sat(p_i1, neg_i1);
  assign oq_next  = real1 ? '0 : round_sat(p_q1, neg_q1);

  // multiply stage, gain is stable for the whole block
  always_ff @(posedge clk) begin
    if (pop) begin
      p_i1   <= PW1'(mag_i) * PW1'(gain);
      p_q1   <= PW1'(mag_q) * PW1'(gain);
      neg_i1 <= hd_i[SB-1];
      neg_q1 <= hd_q[SB-1];
      real1  <= mode_real;
      last1  <= hd_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (pop) begin
      v1 <= 1'b1;
    end else if (adv) begin
      v1 <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_i <= oi_next;
      out_q <= oq_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // square stage, independent of output stalls
  always_ff @(posedge clk) begin
    if (load_out) begin
      oi3   <= oi_next;
      oq3   <= oq_next;
      last3 <= last1;
    end
    if (v3) begin
      sq_i4 <= PKW'(oi3 * oi3);
      sq_q4 <= PKW'(oq3 * oq3);
      last4 <= last3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v3 <= load_out;
      v4 <= v3;
    end
  end

  assign msq = sq_i4 + sq_q4;

  // peak, count and block hold
  always_ff @(posedge clk) begin
    if (rst) begin
      peak      <= '0;
      count     <= '0;
      hold      <= 1'b0;
      upd_start <= 1'b0;
    end else begin
      upd_start <= v4 & last4;
      if (upd_done) begin
        peak  <= '0;
        count <= '0;
        hold  <= 1'b0;
      end else begin
        if (v4 && msq > peak) begin
          peak <= msq;
        end
        if (pop) begin
          if (count < CNT_BITS'(MAX_BLOCK)) begin
            count <= count + 1'b1;
          end
          if (hd_last) begin
            hold <= 1'b1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/bpagc_gain.sv @@
// gain register and block-end update: isqrt, error, rate multiply, clamp
`default_nettype none

module bpagc_gain
  import bpagc_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int GAIN_BITS   = 24,
  parameter int CNT_BITS    = 13
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [2*SAMPLE_BITS-1:0]   peak,
  input  logic [CNT_BITS-1:0]        count,
  input  logic [REF_BITS-1:0]        reference_level,
  input  logic [RATE_BITS-1:0]       loop_rate,
  input  logic [CFG_GAIN_BITS-1:0]   gain_ceiling,
  input  logic                       load_gain,
  input  logic [CFG_GAIN_BITS-1:0]   load_value,
  output logic [GAIN_BITS-1:0]       gain,
  output logic                       busy,
  output logic                       done
);

  localparam int SB    = SAMPLE_BITS;
  localparam int PKW   = 2*SB;
  localparam int REMW  = SB + 3;
  localparam int STEPW = $clog2(SB);
  localparam int ABSW  = (SB > REF_BITS) ? SB : REF_BITS;
  localparam int AW    = ABSW + CNT_BITS;
  localparam int PLW   = AW + RATE_HALF;
  localparam int FULLW = AW + RATE_BITS;
  localparam int DW    = FULLW - RATE_SHIFT;
  localparam int GW0   = (GAIN_BITS > DW) ? GAIN_BITS : DW;
  localparam int GW0C  = (GW0 > CFG_GAIN_BITS) ? GW0 : CFG_GAIN_BITS;
  localparam int SW    = GW0C + 2;

  localparam logic signed [SW-1:0] GMAX = SW'((64'd1 << GAIN_BITS) - 64'd1);

  upd_state_t       state;
  logic [STEPW-1:0] step;
  logic [PKW-1:0]   x;
  logic [REMW-1:0]  rem;
  logic [SB-1:0]    root;
  logic [ABSW-1:0]  abs_err;
  logic             err_neg;
  logic [AW-1:0]    a;
  logic [PLW-1:0]   p_lo;
  logic [PLW-1:0]   p_hi;
  logic [DW-1:0]    delta;

  logic [REMW-1:0]  rem_sh;
  logic [REMW-1:0]  trial;
  logic             fits;
  logic [ABSW-1:0]  ref_ext;
  logic [ABSW-1:0]  mag_ext;
  logic [FULLW-1:0] full;
  logic signed [SW-1:0] g_sum;
  logic signed [SW-1:0] g_sat;
  logic signed [SW-1:0] g_clamp;

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_APPLY);

  // one root digit per cycle
  assign rem_sh = {rem[REMW-3:0], x[PKW-1:PKW-2]};
  assign trial  = REMW'({root, 2'b01});
  assign fits   = (rem_sh >= trial);

  assign ref_ext = ABSW'(reference_level);
  assign mag_ext = ABSW'(root);

  // delta = (a * rate) >> 31 from two half-rate partial products
  assign full  = FULLW'(p_lo) + (FULLW'(p_hi) << RATE_HALF);

  // signed update, floor at zero, saturate, optional ceiling
  always_comb begin
    if (err_neg) begin
      g_sum = SW'(gain) - SW'(delta);
    end else begin
      g_sum = SW'(gain) + SW'(delta);
    end
    if (g_sum < 0) begin
      g_sat = '0;
    end else if (g_sum > GMAX) begin
      g_sat = GMAX;
    end else begin
      g_sat = g_sum;
    end
    if (gain_ceiling != '0 && g_sat > SW'(gain_ceiling)) begin
      g_clamp = SW'(gain_ceiling);
    end else begin
      g_clamp = g_sat;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE:   if (start) state <= ST_SQRT;
        ST_SQRT:   if (step == '0) state <= ST_ERR;
        ST_ERR:    state <= ST_MUL_A;
        ST_MUL_A:  state <= ST_MUL_LO;
        ST_MUL_LO: state <= ST_MUL_HI;
        ST_MUL_HI: state <= ST_SUM;
        ST_SUM:    state <= ST_APPLY;
        ST_APPLY:  state <= ST_IDLE;
        default:   state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          x    <= peak;
          rem  <= '0;
          root <= '0;
          step <= STEPW'(SB - 1);
        end
      end
      ST_SQRT: begin
        x    <= x << 2;
        step <= step - 1'b1;
        if (fits) begin
          rem  <= rem_sh - trial;
          root <= {root[SB-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[SB-2:0], 1'b0};
        end
      end
      ST_ERR: begin
        if (ref_ext >= mag_ext) begin
          abs_err <= ref_ext - mag_ext;
          err_neg <= 1'b0;
        end else begin
          abs_err <= mag_ext - ref_ext;
          err_neg <= 1'b1;
        end
      end
      ST_MUL_A:  a     <= AW'(abs_err) * AW'(count);
      ST_MUL_LO: p_lo  <= PLW'(a) * PLW'(loop_rate[RATE_HALF-1:0]);
      ST_MUL_HI: p_hi  <= PLW'(a) * PLW'(loop_rate[RATE_BITS-1:RATE_HALF]);
      ST_SUM:    delta <= full[FULLW-1:RATE_SHIFT];
      default: begin
      end
    endcase
  end

  // gain register
  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_BITS'(GAIN_UNITY);
    end else if (load_gain) begin
      gain <= GAIN_BITS'(load_value);
    end else if (state == ST_APPLY) begin
      gain <= g_clamp[GAIN_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

@@ rtl/block_peak_agc.sv @@
// top level of the block peak agc: ports, register file, front and back
//
// Samples enter on the s_axis channel (tdata = i, q; tlast closes a block)
// and leave scaled by the current gain on the m_axis channel, one result
// per sample, in order. Registers sit on the apb port at byte address 4*i.
// An accepted beat goes into a four-entry queue; the scaler pops it, runs
// the gain multiply into its multiply register and puts the saturated
// result in the output register. Inside a block one sample goes through
// per cycle while the output is not stalled. When the sample marked last
// has been popped, the scaler holds the queue through its multiply stage,
// the square and peak stages, the start strobe, the integer square root
// (one root bit per cycle) and the error, rate multiply, sum and clamp
// states, so the queue pops nothing at each block end until the gain
// update is done; the input takes up to four more beats meanwhile. The
// first sample of the next block sees the new gain.
// A stalled m_axis_tready holds the output register and backs up into the
// queue and then s_axis_tready. Reset (synchronous) empties the queue and
// pipeline, loads unity gain and the register reset values and clears the
// peak and the sample count. Write registers only while the block is idle.
`default_nettype none

module block_peak_agc
  import bpagc_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int GAIN_BITS   = 24,
  parameter int MAX_BLOCK   = 4096
) (
  input  logic                                      clk,
  input  logic                                      rst,
  // sample input
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]        s_axis_tdata,  // in_i, in_q
  input  logic                                      s_axis_tlast,  // last_of_block
  // scaled output
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]        m_axis_tdata,  // out_i, out_q
  // register port
  input  logic                                      psel,
  input  logic                                      penable,
  input  logic                                      pwrite,
  input  logic [APB_ADDR_BITS-1:0]                  paddr,
  input  logic [APB_DATA_BITS-1:0]                  pwdata,
  output logic [APB_DATA_BITS-1:0]                  prdata,
  output logic                                      pready
);

  localparam int SB       = SAMPLE_BITS;
  localparam int TDW      = ((2*SAMPLE_BITS+7)/8)*8;
  localparam int CNT_BITS = $clog2(MAX_BLOCK + 1);

  // registers
  logic                     mode_real;
  logic [REF_BITS-1:0]      reference_level;
  logic [RATE_BITS-1:0]     loop_rate;
  logic [CFG_GAIN_BITS-1:0] gain_ceiling;
  logic [CFG_GAIN_BITS-1:0] initial_gain;

  logic                     cfg_wr;
  reg_idx_t                 cfg_idx;
  logic                     load_gain;

  // internal links
  logic                     head_valid;
  logic [2*SB:0]            head;
  logic                     q_pop;
  logic [SB-1:0]            out_i;
  logic [SB-1:0]            out_q;
  logic                     blk_hold;
  logic                     upd_start;
  logic                     upd_done;
  logic                     upd_busy;
  logic [2*SB-1:0]          peak;
  logic [CNT_BITS-1:0]      count;
  logic [GAIN_BITS-1:0]     gain;

  assign pready    = 1'b1;
  assign cfg_idx   = reg_idx_t'(paddr[APB_ADDR_BITS-1:2]);
  assign cfg_wr    = psel & penable & pwrite & pready;
  assign load_gain = cfg_wr & (cfg_idx == REG_INITIAL_GAIN);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_real       <= 1'b0;
      reference_level <= RST_REFERENCE;
      loop_rate       <= RST_LOOP_RATE;
      gain_ceiling    <= RST_GAIN_CEILING;
      initial_gain    <= RST_INIT_GAIN;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MODE_REAL:    mode_real       <= pwdata[0];
        REG_REFERENCE:    reference_level <= pwdata[REF_BITS-1:0];
        REG_LOOP_RATE:    loop_rate       <= pwdata[RATE_BITS-1:0];
        REG_GAIN_CEILING: gain_ceiling    <= pwdata[CFG_GAIN_BITS-1:0];
        REG_INITIAL_GAIN: initial_gain    <= pwdata[CFG_GAIN_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // register reads
  always_comb begin
    case (cfg_idx)
      REG_MODE_REAL:    prdata = APB_DATA_BITS'(mode_real);
      REG_REFERENCE:    prdata = APB_DATA_BITS'(reference_level);
      REG_LOOP_RATE:    prdata = APB_DATA_BITS'(loop_rate);
      REG_GAIN_CEILING: prdata = APB_DATA_BITS'(gain_ceiling);
      REG_INITIAL_GAIN: prdata = APB_DATA_BITS'(initial_gain);
      default:          prdata = '0;
    endcase
  end

  // front: input queue
  bpagc_queue #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_i       (s_axis_tdata[SB-1:0]),
    .in_q       (s_axis_tdata[2*SB-1:SB]),
    .in_last    (s_axis_tlast),
    .head_valid (head_valid),
    .head       (head),
    .pop        (q_pop)
  );

  // back: scaling pipeline
  bpagc_scaler #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .GAIN_BITS   (GAIN_BITS),
    .MAX_BLOCK   (MAX_BLOCK),
    .CNT_BITS    (CNT_BITS)
  ) u_scaler (
    .clk        (clk),
    .rst        (rst),
    .mode_real  (mode_real),
    .gain       (gain),
    .head_valid (head_valid),
    .head       (head),
    .pop        (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_i      (out_i),
    .out_q      (out_q),
    .hold       (blk_hold),
    .upd_start  (upd_start),
    .upd_done   (upd_done),
    .peak       (peak),
    .count      (count)
  );

  // back: gain update at block end
  bpagc_gain #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .GAIN_BITS   (GAIN_BITS),
    .CNT_BITS    (CNT_BITS)
  ) u_gain (
    .clk             (clk),
    .rst             (rst),
    .start           (upd_start),
    .peak            (peak),
    .count           (count),
    .reference_level (reference_level),
    .loop_rate       (loop_rate),
    .gain_ceiling    (gain_ceiling),
    .load_gain       (load_gain),
    .load_value      (pwdata[CFG_GAIN_BITS-1:0]),
    .gain            (gain),
    .busy            (upd_busy),
    .done            (upd_done)
  );

  assign m_axis_tdata = TDW'({out_q, out_i});

  // no sample leaves the queue while the gain is being updated
  a_no_pop_in_update: assert property (@(posedge clk) disable iff (rst)
    upd_busy |-> !q_pop)
    else $error("queue popped during gain update");

  // an update only starts for a block that is being held
  a_start_in_hold: assert property (@(posedge clk) disable iff (rst)
    upd_start |-> blk_hold)
    else $error("gain update started outside a held block");

  // writing initial_gain loads the gain register
  a_gain_load: assert property (@(posedge clk) disable iff (rst)
    load_gain |=> gain == GAIN_BITS'($past(pwdata[CFG_GAIN_BITS-1:0])))
    else $error("initial_gain write did not load the gain");

endmodule

`default_nettype wire
